// File: rtl/core/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared constants and helpers for the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int MAX_DIGITS  = 16;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int COUNT_W     = 5;
    localparam int VALUE_W     = 64;
    localparam int LOW_W       = 32;
    localparam int CHAR_W      = 8;

    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_LHEX = 3'd2;
    localparam logic [2:0] KIND_UHEX = 3'd3;
    localparam logic [2:0] KIND_PTR  = 3'd4;

    localparam logic [1:0] PREFIX_NONE  = 2'd0;
    localparam logic [1:0] PREFIX_MINUS = 2'd1;
    localparam logic [1:0] PREFIX_HEX   = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;

    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] base;
        begin
            base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
            if (d < 4'd10)
            begin
                digit_char = CHAR_ZERO + {4'd0, d};
            end
            else
            begin
                digit_char = base + {4'd0, d - 4'd10};
            end
        end
    endfunction

endpackage

// File: rtl/core/i2a_digit_unit.sv
// ----------------------------------------------------------------------------
// i2a_digit_unit
// Shared digit step: splits off the lowest digit of a magnitude in radix
// ten (reciprocal multiply) or sixteen (shift), and returns the quotient.
// ----------------------------------------------------------------------------
module i2a_digit_unit (
    input  logic [i2a_pkg::VALUE_W-1:0] mag,
    input  logic                        hex,
    output logic [i2a_pkg::VALUE_W-1:0] quot,
    output logic [3:0]                  digit
);

    localparam int QW = i2a_pkg::LOW_W - (i2a_pkg::RECIP10_SHIFT - i2a_pkg::LOW_W);

    logic [63:0]                  prod;
    logic [QW-1:0]                q10;
    logic [i2a_pkg::LOW_W-1:0]    q_times10;
    logic [i2a_pkg::LOW_W-1:0]    rem;

    always_comb
    begin
        prod      = 64'(mag[i2a_pkg::LOW_W-1:0]) * 64'(i2a_pkg::RECIP10);
        q10       = prod[63:i2a_pkg::RECIP10_SHIFT];
        q_times10 = 32'({q10, 3'b000}) + 32'({q10, 1'b0});
        rem       = mag[i2a_pkg::LOW_W-1:0] - q_times10;
        if (hex)
        begin
            quot  = {4'd0, mag[i2a_pkg::VALUE_W-1:4]};
            digit = mag[3:0];
        end
        else
        begin
            quot  = 64'(q10);
            digit = rem[3:0];
        end
    end

endmodule

// File: rtl/core/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats one integer per item as ASCII text, most significant digit first.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                      Marks
// s_*       in   tdata[63:0] value                            tuser[2:0] kind
// m_*       out  tdata[7:0] character, tdata[12:8] length     tlast last
//
// After accept, the shared digit unit splits off one digit per cycle (1 to 16
// digits), and the text leaves at one character per cycle while m_tready is high.
// Kinds 5 to 7 are taken and dropped. Reset clears the sequencer and the output
// valid; m_tready low holds the current character, and a new item may convert
// while the last one waits.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value[63:0]
    input  logic [7:0]  s_tuser,   // kind[2:0], zeros[7:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // character[7:0], total_length[12:8], zeros[15:13]
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                               state_reg;
    logic [i2a_pkg::VALUE_W-1:0]          mag_reg;
    logic                                 hex_reg;
    logic                                 upper_reg;
    logic [1:0]                           prefix_reg;
    logic [i2a_pkg::COUNT_W-1:0]          n_reg;
    logic [i2a_pkg::COUNT_W-1:0]          len_reg;
    logic [i2a_pkg::COUNT_W-1:0]          pos_reg;
    logic [3:0]                           buf_reg [i2a_pkg::MAX_DIGITS];

    logic                                 m_tvalid_reg;
    logic [i2a_pkg::CHAR_W-1:0]           m_char_reg;
    logic                                 m_tlast_reg;
    logic [i2a_pkg::COUNT_W-1:0]          m_len_reg;

    logic [i2a_pkg::VALUE_W-1:0]          quot;
    logic [3:0]                           digit;
    logic [i2a_pkg::LOW_W-1:0]            low;
    logic                                 in_acc;
    logic                                 out_free;
    logic                                 conv_done;
    logic                                 is_last;
    logic [i2a_pkg::COUNT_W-1:0]          rd_idx;
    logic [i2a_pkg::CHAR_W-1:0]           char_next;

    i2a_digit_unit u_digit (
        .mag   (mag_reg),
        .hex   (hex_reg),
        .quot  (quot),
        .digit (digit)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign low       = s_tdata[i2a_pkg::LOW_W-1:0];
    assign out_free  = !m_tvalid_reg || m_tready;
    assign conv_done = (quot == '0) ||
                       (n_reg == i2a_pkg::COUNT_W'(i2a_pkg::MAX_DIGITS - 1));
    assign is_last   = (pos_reg == len_reg - 5'd1);
    assign rd_idx    = len_reg - 5'd1 - pos_reg;

    always_comb
    begin
        if (pos_reg < 5'(prefix_reg))
        begin
            if (prefix_reg == i2a_pkg::PREFIX_MINUS)
            begin
                char_next = i2a_pkg::CHAR_MINUS;
            end
            else
            begin
                char_next = pos_reg[0] ? i2a_pkg::CHAR_X : i2a_pkg::CHAR_ZERO;
            end
        end
        else
        begin
            char_next = i2a_pkg::digit_char(buf_reg[rd_idx[i2a_pkg::DIGIT_IDX_W-1:0]],
                                            upper_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            n_reg        <= '0;
            pos_reg      <= '0;
            len_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        n_reg <= '0;
                        if (s_tuser[2:0] <= i2a_pkg::KIND_PTR)
                        begin
                            state_reg <= ST_CONV;
                        end
                    end
                end
                ST_CONV:
                begin
                    n_reg <= n_reg + 5'd1;
                    if (conv_done)
                    begin
                        len_reg   <= 5'(prefix_reg) + n_reg + 5'd1;
                        pos_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        pos_reg <= pos_reg + 5'd1;
                        if (is_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (state_reg == ST_EMIT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            hex_reg    <= 1'b0;
            upper_reg  <= 1'b0;
            prefix_reg <= i2a_pkg::PREFIX_NONE;
            mag_reg    <= 64'(low);
            case (s_tuser[2:0])
                i2a_pkg::KIND_SDEC:
                begin
                    if (low[i2a_pkg::LOW_W-1])
                    begin
                        prefix_reg <= i2a_pkg::PREFIX_MINUS;
                        mag_reg    <= 64'((~low) + 32'd1);
                    end
                end
                i2a_pkg::KIND_LHEX:
                begin
                    hex_reg <= 1'b1;
                end
                i2a_pkg::KIND_UHEX:
                begin
                    hex_reg   <= 1'b1;
                    upper_reg <= 1'b1;
                end
                i2a_pkg::KIND_PTR:
                begin
                    hex_reg    <= 1'b1;
                    prefix_reg <= i2a_pkg::PREFIX_HEX;
                    mag_reg    <= s_tdata;
                end
                default:
                begin
                    hex_reg <= 1'b0;
                end
            endcase
        end
        else if (state_reg == ST_CONV)
        begin
            buf_reg[n_reg[i2a_pkg::DIGIT_IDX_W-1:0]] <= digit;
            mag_reg                                 <= quot;
        end

        if (state_reg == ST_EMIT && out_free)
        begin
            m_char_reg  <= char_next;
            m_tlast_reg <= is_last;
            m_len_reg   <= len_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, m_len_reg, m_char_reg};
    assign m_tlast  = m_tlast_reg;

    a_conv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV |-> n_reg < 5'(i2a_pkg::MAX_DIGITS))
        else $error("digit count overran the buffer");

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> len_reg >= 5'd1 && pos_reg < len_reg)
        else $error("emit position outside the text");

    a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[2:0] <= i2a_pkg::KIND_PTR
        |=> state_reg == ST_CONV)
        else $error("valid kind did not start a conversion");

endmodule
